// ===== sv/lst_pkg.sv =====
// lst_pkg: request and response words, operation codes and fixed constants
// for the liveness slot table. No dependencies.
package lst_pkg;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_CREATE = 3'd1;
   localparam logic [2:0] OP_FIND   = 3'd2;
   localparam logic [2:0] OP_TOUCH  = 3'd3;
   localparam logic [2:0] OP_NTH    = 3'd4;
   localparam logic [2:0] OP_COUNT  = 3'd5;
   localparam logic [2:0] OP_READ   = 3'd6;
   localparam logic [2:0] OP_NONE   = 3'd7;

   localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
   localparam logic [4:0]  ACTIVE_MAX    = 5'd31;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] key_id;
      logic [7:0]  position;
   } lst_req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  slot_index;
      logic [15:0] slot_id;
      logic        connected;
      logic [4:0]  live_total;
   } lst_rsp_type;

endpackage

// ===== sv/liveness_slot_table.sv =====
// liveness_slot_table: slot table of ids and timestamps with one shared
// age compare unit walking the slots in order. Depends on lst_pkg.
//
// tick and the unused op: result strobed the cycle after acceptance, one per cycle.
// all other ops: one slot read per cycle through the single memory read port,
// result strobed after the walk through all slots and the finish state; busy until then.
// reset (synchronous): table empty, time zero, timeout 3000, no result pending.
// results cannot be stalled; each strobe lasts one cycle.
module liveness_slot_table #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lst_pkg::lst_req_type req,
   output logic                rsp_valid,
   output lst_pkg::lst_rsp_type rsp,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_data
);
   import lst_pkg::*;

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   // slot memory, no reset: valid bits stand in for the cleared table
   logic [15:0] mem_id    [NUM_SLOTS];
   logic [31:0] mem_stamp [NUM_SLOTS];

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lst_rsp_type          rsp_ff, rsp_in;
   logic [31:0]          now_ff, now_in;
   logic [15:0]          timeout_ff, timeout_in;
   logic [NUM_SLOTS-1:0] vld_ff, vld_in;
   lst_req_type          req_ff, req_in;
   logic [CW-1:0]        addr_ff, addr_in;
   logic                 pend_ff, pend_in;
   logic [IW-1:0]        pend_idx_ff, pend_idx_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [15:0]          rd_id_ff;
   logic [31:0]          rd_stamp_ff;
   logic                 hit_ff, hit_in;
   logic [IW-1:0]        hit_idx_ff, hit_idx_in;
   logic [15:0]          hit_id_ff, hit_id_in;
   logic                 hit_live_ff, hit_live_in;
   logic                 empty_ff, empty_in;
   logic [IW-1:0]        empty_idx_ff, empty_idx_in;
   logic [CW-1:0]        live_cnt_ff, live_cnt_in;

   logic                 rd_en;
   logic [15:0]          id_m;
   logic [31:0]          stamp_m;
   logic [31:0]          age;
   logic                 live;
   logic                 match;
   logic                 id_we, stamp_we;
   logic [IW-1:0]        wr_idx;
   logic [15:0]          wr_id;
   logic [31:0]          wr_stamp;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign csr_ready = 1'b1;

   assign rd_en = (state_ff == ST_SCAN) && (addr_ff < CW'(NUM_SLOTS));

   // shared age compare on the word read last cycle
   assign id_m    = rd_vld_ff ? rd_id_ff : 16'd0;
   assign stamp_m = rd_vld_ff ? rd_stamp_ff : 32'd0;
   assign age     = now_ff - stamp_m;
   assign live    = (id_m != 16'd0) && (stamp_m != 32'd0) && (age < {16'd0, timeout_ff});

   always_comb begin
      case (req_ff.op)
         OP_CREATE, OP_FIND, OP_TOUCH: match = (req_ff.key_id != 16'd0) &&
                                               (id_m == req_ff.key_id);
         OP_NTH:  match = live && (9'(live_cnt_ff) == {1'b0, req_ff.position});
         OP_READ: match = (9'(pend_idx_ff) == {1'b0, req_ff.position});
         default: match = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      now_in       = now_ff;
      timeout_in   = timeout_ff;
      vld_in       = vld_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      pend_in      = 1'b0;
      pend_idx_in  = addr_ff[IW-1:0];
      rd_vld_in    = rd_en ? vld_ff[addr_ff[IW-1:0]] : 1'b0;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_id_in    = hit_id_ff;
      hit_live_in  = hit_live_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      live_cnt_in  = live_cnt_ff;
      id_we        = 1'b0;
      stamp_we     = 1'b0;
      wr_idx       = hit_idx_ff;
      wr_id        = req_ff.key_id;
      wr_stamp     = now_ff;

      if (csr_valid) begin
         timeout_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req;
               if (req.op == OP_TICK || req.op == OP_NONE) begin
                  if (req.op == OP_TICK) begin
                     now_in = now_ff + 32'd1;
                  end
                  rsp_in       = '0;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in    = ST_SCAN;
                  addr_in     = '0;
                  hit_in      = 1'b0;
                  empty_in    = 1'b0;
                  live_cnt_in = '0;
               end
            end
         end
         ST_SCAN: begin
            pend_in = rd_en;
            if (rd_en) begin
               addr_in = addr_ff + CW'(1);
            end
            if (pend_ff) begin
               if (match && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = pend_idx_ff;
                  hit_id_in   = id_m;
                  hit_live_in = live;
               end
               if (id_m == 16'd0 && !empty_ff) begin
                  empty_in     = 1'b1;
                  empty_idx_in = pend_idx_ff;
               end
               if (live) begin
                  live_cnt_in = live_cnt_ff + CW'(1);
               end
            end
            if (!pend_ff && !rd_en) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            case (req_ff.op)
               OP_CREATE: begin
                  if (req_ff.key_id != 16'd0 && !hit_ff && empty_ff) begin
                     rsp_in.found      = 1'b1;
                     rsp_in.slot_index = 4'(empty_idx_ff);
                     rsp_in.slot_id    = req_ff.key_id;
                     id_we             = 1'b1;
                     stamp_we          = 1'b1;
                     wr_idx            = empty_idx_ff;
                     wr_stamp          = 32'd0;
                     vld_in[empty_idx_ff] = 1'b1;
                  end
               end
               OP_FIND, OP_NTH, OP_READ: begin
                  if (hit_ff) begin
                     rsp_in.found      = 1'b1;
                     rsp_in.slot_index = 4'(hit_idx_ff);
                     rsp_in.slot_id    = hit_id_ff;
                     rsp_in.connected  = hit_live_ff;
                  end
               end
               OP_TOUCH: begin
                  if (hit_ff) begin
                     rsp_in.found      = 1'b1;
                     rsp_in.slot_index = 4'(hit_idx_ff);
                     rsp_in.slot_id    = hit_id_ff;
                     // freshly stamped: age zero, live unless stamp or timeout is zero
                     rsp_in.connected  = (now_ff != 32'd0) && (timeout_ff != 16'd0);
                     stamp_we          = 1'b1;
                  end
               end
               OP_COUNT: begin
                  rsp_in.found      = 1'b1;
                  rsp_in.live_total = (9'(live_cnt_ff) > 9'(ACTIVE_MAX)) ?
                                      ACTIVE_MAX : 5'(live_cnt_ff);
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      req_ff       <= req_in;
      addr_ff      <= addr_in;
      pend_idx_ff  <= pend_idx_in;
      rd_vld_ff    <= rd_vld_in;
      hit_idx_ff   <= hit_idx_in;
      hit_id_ff    <= hit_id_in;
      hit_live_ff  <= hit_live_in;
      empty_idx_ff <= empty_idx_in;
      live_cnt_ff  <= live_cnt_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         now_ff       <= 32'd0;
         timeout_ff   <= TIMEOUT_RESET;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         empty_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         now_ff       <= now_in;
         timeout_ff   <= timeout_in;
         vld_ff       <= vld_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         empty_ff     <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         mem_id[wr_idx] <= wr_id;
      end
      if (stamp_we) begin
         mem_stamp[wr_idx] <= wr_stamp;
      end
      if (rd_en) begin
         rd_id_ff    <= mem_id[addr_ff[IW-1:0]];
         rd_stamp_ff <= mem_stamp[addr_ff[IW-1:0]];
      end
   end

endmodule

// ===== sv/lst_checker.sv =====
// lst_checker: port-level checks on the liveness slot table, bound to the
// top level below. Depends on lst_pkg.
module lst_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input lst_pkg::lst_req_type req,
   input logic                 rsp_valid,
   input lst_pkg::lst_rsp_type rsp
);
   import lst_pkg::*;

   // tick and the unused op answer at once with an all-zero word
   a_quick_ops : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req.op == OP_TICK || req.op == OP_NONE))
      |=> (rsp_valid && rsp == '0 && !busy))
      else $error("tick or unused op did not give an immediate zero word");

   // a table walk keeps the block busy
   a_scan_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.op != OP_TICK && req.op != OP_NONE) |=> busy)
      else $error("block not busy after accepting a table op");

   // failures come back all zero
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.found) |-> (rsp == '0))
      else $error("failed word carries nonzero fields");

   // a count word carries no slot
   a_count_only : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.live_total != 5'd0)
      |-> (rsp.found && rsp.slot_index == 4'd0 && rsp.slot_id == 16'd0 && !rsp.connected))
      else $error("count word carries slot fields");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not quiet after reset");

endmodule

bind liveness_slot_table lst_checker u_lst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);
